// ===== hdl/dpf_pkg.sv =====
package dpf_pkg;

  // defaults for the top level parameters
  localparam int HISTORY_DEPTH_DEF    = 10;
  localparam int MAX_PACKET_BYTES_DEF = 251;

  // fixed field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 8;

  // ring positions and slots stay below 16 as long as HistDepth is at most 15
  localparam int IDX_W  = 4;
  localparam int SLOT_W = 4;

  // controller to datapath
  typedef struct packed {
    logic             accept;     // latch the incoming word
    logic             wr_en;      // write the word into the spare slot
    logic             rd_en;      // read one history entry at the current position
    logic [IDX_W-1:0] rd_idx;     // ring position to read
    logic             count_inc;  // byte kept, advance the count
    logic             set_ovf;    // byte dropped
    logic             use_head;   // select the ring head on the slot map port
    logic             commit;     // final decision, load the result register
  } dpf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;      // packet already holds the maximum byte count
    logic out_free;  // result register can take a new word
  } dpf_status_t;

endpackage

// ===== hdl/duplicate_packet_filter.sv =====
// channel | direction | handshake              | payload
// in      | receive   | in_valid_i / in_stall_o   | data_byte_i, last_byte_i
// out     | send      | out_valid_o / out_stall_i | is_new_o, packet_length_o, truncated_o
//
// a kept word takes a store write, then one history read
// per cycle on the single store read port, then a drain step settling the last compare
// a word past MaxBytes is dropped without a sweep; a final word adds a decision step
// reset clears the ring, lengths and slot map at once, the byte store needs no pass
// a result waits in an output register; the next packet's words are taken meanwhile
// sweep and decision hold the input; a result meeting a stalled output register waits
module duplicate_packet_filter #(
  parameter int HistDepth = dpf_pkg::HISTORY_DEPTH_DEF,
  parameter int MaxBytes  = dpf_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [dpf_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                      last_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      is_new_o,
  output logic [dpf_pkg::LEN_W-1:0]  packet_length_o,
  output logic                      truncated_o
);
  import dpf_pkg::*;

  // command and status between sequencer and datapath
  dpf_cmd_t    cmd;
  dpf_status_t status;

  // sequencer: accept, read sweep over the ring, final decision
  dpf_ctrl #(
    .HistDepth (HistDepth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .last_byte_i (last_byte_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // byte store, ring bookkeeping, match flags and result register
  dpf_datapath #(
    .HistDepth (HistDepth),
    .MaxBytes  (MaxBytes)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .is_new_o        (is_new_o),
    .packet_length_o (packet_length_o),
    .truncated_o     (truncated_o)
  );

endmodule

// ===== hdl/dpf_ctrl.sv =====
module dpf_ctrl #(
  parameter int HistDepth = dpf_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                last_byte_i,
  input  dpf_pkg::dpf_status_t status_i,
  output dpf_pkg::dpf_cmd_t    cmd_o
);
  import dpf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_COMPARE = 4'b0010,
    ST_DRAIN   = 4'b0100,
    ST_DECIDE  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             last_q, last_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    last_d  = last_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          last_d       = last_byte_i;
          if (!status_i.full) begin
            cmd_o.wr_en = 1'b1;
            idx_d       = '0;
            state_d     = ST_COMPARE;
          end else begin
            cmd_o.set_ovf = 1'b1;
            state_d       = last_byte_i ? ST_DECIDE : ST_IDLE;
          end
        end
      end
      ST_COMPARE: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_idx = idx_q;
        if (idx_q == IDX_W'(HistDepth - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        cmd_o.count_inc = 1'b1;
        state_d         = last_q ? ST_DECIDE : ST_IDLE;
      end
      ST_DECIDE: begin
        cmd_o.use_head = 1'b1;
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
    end
  end

  // a read sweep always ends on the last ring position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> ($past(cmd_o.rd_idx) == IDX_W'(HistDepth - 1)))
    else $error("drain entered before the sweep finished");

  // the decision waits for a free result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> status_i.out_free)
    else $error("commit while result register busy");

  // a dropped word never starts a read sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.set_ovf |=> (state_q != ST_COMPARE))
    else $error("sweep after dropped word");

endmodule

// ===== hdl/dpf_datapath.sv =====
module dpf_datapath #(
  parameter int HistDepth = dpf_pkg::HISTORY_DEPTH_DEF,
  parameter int MaxBytes  = dpf_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dpf_pkg::dpf_cmd_t             cmd_i,
  output dpf_pkg::dpf_status_t          status_o,
  input  logic [dpf_pkg::BYTE_W-1:0]    data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         is_new_o,
  output logic [dpf_pkg::LEN_W-1:0]     packet_length_o,
  output logic                         truncated_o
);
  import dpf_pkg::*;

  localparam int SlotCount = HistDepth + 1;
  localparam int MemDepth  = SlotCount * MaxBytes;
  localparam int AddrW     = $clog2(MemDepth);

  // packet byte store, one slot of MaxBytes per history entry plus the spare
  logic [BYTE_W-1:0] pkt_mem [MemDepth];

  logic [SLOT_W-1:0]    slot_map_q [HistDepth];
  logic [LEN_W-1:0]     pos_len_q  [HistDepth];
  logic [SLOT_W-1:0]    spare_q;
  logic [IDX_W-1:0]     head_q;
  logic [LEN_W-1:0]     count_q;
  logic [HistDepth-1:0] flags_q;
  logic                 ovf_q;

  logic [BYTE_W-1:0]    byte_q;
  logic [BYTE_W-1:0]    rd_data_q;
  logic [IDX_W-1:0]     cmp_idx_q;
  logic                 cmp_en_q;

  logic                 out_valid_q;
  logic                 is_new_q;
  logic [LEN_W-1:0]     len_q;
  logic                 trunc_q;

  logic [IDX_W-1:0]     sel_idx;
  logic [SLOT_W-1:0]    sel_slot;
  logic [SLOT_W-1:0]    addr_slot;
  logic [AddrW-1:0]     addr;
  logic                 mismatch;
  logic                 dup;
  logic [IDX_W-1:0]     head_next;

  // one read port on the slot map, shared by the sweep and the ring head
  assign sel_idx   = cmd_i.use_head ? head_q : cmd_i.rd_idx;
  assign sel_slot  = slot_map_q[sel_idx];
  assign addr_slot = cmd_i.wr_en ? spare_q : sel_slot;
  assign addr      = AddrW'(addr_slot) * AddrW'(MaxBytes) + AddrW'(count_q);

  // short entry or differing byte drops the entry
  assign mismatch  = (count_q >= pos_len_q[cmp_idx_q]) || (rd_data_q != byte_q);

  always_comb begin
    dup = 1'b0;
    for (int i = 0; i < HistDepth; i++) begin
      if (flags_q[i] && (pos_len_q[i] == count_q)) begin
        dup = 1'b1;
      end
    end
  end

  assign head_next = (head_q == IDX_W'(HistDepth - 1)) ? '0 : head_q + 1'b1;

  assign status_o.full     = (count_q >= LEN_W'(MaxBytes));
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      pkt_mem[addr] <= data_byte_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= pkt_mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= data_byte_i;
    end
    cmp_idx_q <= cmd_i.rd_idx;
    if (cmd_i.commit) begin
      is_new_q <= !dup;
      len_q    <= count_q;
      trunc_q  <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HistDepth; i++) begin
        slot_map_q[i] <= SLOT_W'(i);
        pos_len_q[i]  <= '0;
      end
      spare_q     <= SLOT_W'(HistDepth);
      head_q      <= '0;
      count_q     <= '0;
      flags_q     <= '1;
      ovf_q       <= 1'b0;
      cmp_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cmp_en_q <= cmd_i.rd_en;
      if (cmp_en_q && mismatch) begin
        flags_q[cmp_idx_q] <= 1'b0;
      end
      if (cmd_i.count_inc) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        count_q <= '0;
        flags_q <= '1;
        ovf_q   <= 1'b0;
        if (!dup) begin
          slot_map_q[head_q] <= spare_q;
          pos_len_q[head_q]  <= count_q;
          spare_q            <= sel_slot;
          head_q             <= head_next;
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_new_o        = is_new_q;
  assign packet_length_o = len_q;
  assign truncated_o     = trunc_q;

  // the spare slot is never one that the ring head points at
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_q != slot_map_q[head_q])
    else $error("spare slot aliases the oldest entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q < IDX_W'(HistDepth))
    else $error("ring head out of range");

  // a new packet's length lands at the old head position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !dup) |=> (pos_len_q[$past(head_q)] == $past(count_q)))
    else $error("stored length not updated");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (out_valid_q && (len_q == $past(count_q))))
    else $error("result register not loaded");

endmodule
